// ===== hdl/ntp_seconds_to_bcd_datetime_defines.svh =====
// assertion macros shared by the block, clocked on clk and disabled in reset
`ifndef NTP_SECONDS_TO_BCD_DATETIME_DEFINES_SVH
`define NTP_SECONDS_TO_BCD_DATETIME_DEFINES_SVH

// same-cycle implication
`define NSBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NSBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/nsbd_pkg.sv =====
`default_nettype none

package nsbd_pkg;

  // stream widths, whole bytes
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 48;

  localparam int QUEUE_DEPTH_DEF = 4;

  // input field positions in in_tdata
  localparam int IN_MODE_LSB   = 0;
  localparam int IN_STRAT_LSB  = 8;
  localparam int IN_LEN_LSB    = 16;
  localparam int IN_PORT_LSB   = 32;
  localparam int IN_MATCH_BIT  = 48;
  localparam int IN_TS_LSB     = 49;

  localparam logic [31:0] NTP_UNIX_DELTA  = 32'd2208988800;
  // four whole weeks keep the local seconds non-negative
  localparam logic [33:0] WEEK_BIAS_SECS  = 34'd2419200;
  // -10800 s, utc-3
  localparam logic [16:0] TZ_RESET        = 17'h1D5D0;
  localparam logic [2:0]  NTP_MODE_SERVER = 3'h4;
  localparam logic [15:0] NTP_SERVER_PORT = 16'd123;
  localparam logic [15:0] NTP_PKT_LEN     = 16'd48;

  // register index, taken from paddr[2]
  localparam logic REG_TZ_OFFSET = 1'b0;

  typedef struct packed {
    logic        ok;
    logic [32:0] secs;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== hdl/nsbd_front.sv =====
`default_nettype none

module nsbd_front import nsbd_pkg::*; (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // mode_byte, stratum, packet_length, source_port, source_matches, transmit_seconds
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [16:0]          tz_offset,
  input  q_stat_t              q_stat,
  output logic                 push,
  output q_entry_t             entry
);

  logic [2:0]  mode;
  logic [7:0]  stratum;
  logic [15:0] pkt_len;
  logic [15:0] src_port;
  logic        src_match;
  logic [31:0] tx_secs;
  logic [31:0] unix_secs;
  logic [33:0] local_sum;

  assign mode      = in_tdata[IN_MODE_LSB +: 3];
  assign stratum   = in_tdata[IN_STRAT_LSB +: 8];
  assign pkt_len   = in_tdata[IN_LEN_LSB +: 16];
  assign src_port  = in_tdata[IN_PORT_LSB +: 16];
  assign src_match = in_tdata[IN_MATCH_BIT];
  assign tx_secs   = in_tdata[IN_TS_LSB +: 32];

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && !q_stat.full;

  // era shift wraps in 32 bits, offset and bias add without wrap
  assign unix_secs = tx_secs - NTP_UNIX_DELTA;
  assign local_sum = {2'b00, unix_secs} + {{17{tz_offset[16]}}, tz_offset} + WEEK_BIAS_SECS;

  always_comb begin
    entry.ok   = src_match && (src_port == NTP_SERVER_PORT) && (pkt_len == NTP_PKT_LEN) &&
                 (mode == NTP_MODE_SERVER) && (stratum != 8'd0);
    entry.secs = local_sum[32:0];
  end

endmodule

`default_nettype wire

// ===== hdl/nsbd_queue.sv =====
`default_nettype none
`include "ntp_seconds_to_bcd_datetime_defines.svh"

module nsbd_queue import nsbd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output q_entry_t head,
  output q_stat_t  q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.avail = (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  `NSBD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH), "queue count beyond depth")
  `NSBD_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + CNT_W'(1), "lost push")
  `NSBD_ASSERT_NOW(a_pop_avail, pop, cnt_r != '0, "pop from empty queue")

endmodule

`default_nettype wire

// ===== hdl/nsbd_back.sv =====
`default_nettype none
`include "ntp_seconds_to_bcd_datetime_defines.svh"

module nsbd_back import nsbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  q_stat_t               q_stat,
  input  q_entry_t              head,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // bcd_seconds, bcd_minutes, bcd_hours, bcd_weekday, bcd_date, bcd_month, bcd_year
  output logic [OUT_DATA_W-1:0] out_tdata,
  // valid_res
  output logic                  out_tuser
);

  localparam int NSTG   = 11;
  localparam int FLD_W  = 42;
  localparam int WD_LSB = 20;

  typedef struct packed {
    logic        ok;
    logic [25:0] q1;
    logic [6:0]  lo7;
    logic [15:0] day;
    logic [16:0] sod;
    logic [17:0] doe;
    logic        era;
    logic [16:0] wdx;
    logic [13:0] q7;
    logic [4:0]  hrs;
    logic [6:0]  d1460;
    logic [2:0]  d36524;
    logic        d146096;
    logic [2:0]  wd;
    logic [11:0] remh;
    logic [17:0] num;
    logic [5:0]  mins;
    logic [8:0]  yoe;
    logic [5:0]  secs;
    logic [1:0]  yoe100;
    logic [11:0] yr_full;
    logic [8:0]  doy;
    logic [3:0]  mp;
    logic [4:0]  date;
    logic [3:0]  mon;
    logic [4:0]  yq;
    logic [6:0]  yr;
  } bk_t;

  // packed bcd of a value below 100
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [17:0] p;
    logic [3:0]  tens;
    p    = 18'(v) * 18'd205;
    tens = p[14:11];
    return {tens, 4'(v - 7'(tens) * 7'd10)};
  endfunction

  // days before month mp, march based
  function automatic logic [8:0] month_ofs(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  logic            adv;
  logic [NSTG-1:0] vld_r, vld_nxt;
  logic            out_vld_r, out_vld_nxt;
  logic            out_ok_r, out_ok_nxt;
  logic [FLD_W-1:0] out_fld_r, out_fld_nxt;

  bk_t s1_r, s1_nxt, s2_r, s2_nxt, s3_r, s3_nxt, s4_r, s4_nxt;
  bk_t s5_r, s5_nxt, s6_r, s6_nxt, s7_r, s7_nxt, s8_r, s8_nxt;
  bk_t s9_r, s9_nxt, s10_r, s10_nxt, s11_r, s11_nxt;

  logic [52:0] p_day;
  logic [25:0] r675;
  logic [35:0] p_wd;
  logic [25:0] p_hrs;
  logic [31:0] p_1460;
  logic [16:0] r_hrs;
  logic [19:0] p_min;
  logic [35:0] p_yoe;
  logic [15:0] p_100;
  logic [17:0] doy_sub;
  logic [10:0] x5;
  logic [21:0] p_mp;
  logic [23:0] p_yq;

  assign adv = !out_vld_r || out_tready;
  assign pop = adv && q_stat.avail;

  // day number: divide by 128 then by 675 via reciprocal
  always_comb begin
    s1_nxt     = '0;
    s1_nxt.ok  = head.ok;
    s1_nxt.q1  = head.secs[32:7];
    s1_nxt.lo7 = head.secs[6:0];
    p_day      = 53'(head.secs[32:7]) * 53'd101806633;
    s1_nxt.day = p_day[51:36];
  end

  // second of day, era split, weekday quotient
  always_comb begin
    s2_nxt     = s1_r;
    r675       = s1_r.q1 - 26'(s1_r.day) * 26'd675;
    s2_nxt.sod = {r675[9:0], s1_r.lo7};
    s2_nxt.era = (s1_r.day >= 16'd11045);
    s2_nxt.doe = (s1_r.day >= 16'd11045) ? 18'(s1_r.day) - 18'd11045
                                         : 18'(s1_r.day) + 18'd135052;
    s2_nxt.wdx = 17'(s1_r.day) + 17'd4;
    p_wd       = 36'(17'(s1_r.day) + 17'd4) * 36'd74899;
    s2_nxt.q7  = p_wd[32:19];
  end

  always_comb begin
    s3_nxt         = s2_r;
    p_hrs          = 26'(s2_r.sod[16:4]) * 26'd4661;
    s3_nxt.hrs     = p_hrs[24:20];
    p_1460         = 32'(s2_r.doe[17:2]) * 32'd45965;
    s3_nxt.d1460   = p_1460[30:24];
    s3_nxt.d36524  = 3'(s2_r.doe >= 18'd36524) + 3'(s2_r.doe >= 18'd73048) +
                     3'(s2_r.doe >= 18'd109572) + 3'(s2_r.doe >= 18'd146096);
    s3_nxt.d146096 = (s2_r.doe == 18'd146096);
    s3_nxt.wd      = 3'(s2_r.wdx - 17'(s2_r.q7) * 17'd7);
  end

  always_comb begin
    s4_nxt      = s3_r;
    r_hrs       = s3_r.sod - 17'(s3_r.hrs) * 17'd3600;
    s4_nxt.remh = r_hrs[11:0];
    s4_nxt.num  = s3_r.doe - 18'(s3_r.d1460) + 18'(s3_r.d36524) - 18'(s3_r.d146096);
  end

  always_comb begin
    s5_nxt      = s4_r;
    p_min       = 20'(s4_r.remh[11:2]) * 20'd1093;
    s5_nxt.mins = p_min[19:14];
    p_yoe       = 36'(s4_r.num) * 36'd183861;
    s5_nxt.yoe  = p_yoe[34:26];
  end

  always_comb begin
    s6_nxt         = s5_r;
    s6_nxt.secs    = 6'(s5_r.remh - 12'(s5_r.mins) * 12'd60);
    p_100          = 16'(s5_r.yoe) * 16'd82;
    s6_nxt.yoe100  = p_100[14:13];
    s6_nxt.yr_full = 12'(s5_r.yoe) + (s5_r.era ? 12'd2000 : 12'd1600);
  end

  always_comb begin
    s7_nxt     = s6_r;
    doy_sub    = 18'(s6_r.yoe) * 18'd365 + 18'(s6_r.yoe[8:2]) - 18'(s6_r.yoe100);
    s7_nxt.doy = 9'(s6_r.doe - doy_sub);
  end

  always_comb begin
    s8_nxt    = s7_r;
    x5        = 11'(s7_r.doy) * 11'd5 + 11'd2;
    p_mp      = 22'(x5) * 22'd1714;
    s8_nxt.mp = p_mp[21:18];
  end

  // january and february belong to the next year
  always_comb begin
    s9_nxt         = s8_r;
    s9_nxt.date    = 5'(s8_r.doy - month_ofs(s8_r.mp) + 9'd1);
    s9_nxt.mon     = (s8_r.mp < 4'd10) ? s8_r.mp + 4'd3 : s8_r.mp - 4'd9;
    s9_nxt.yr_full = s8_r.yr_full + 12'(s8_r.mp >= 4'd10);
  end

  always_comb begin
    s10_nxt    = s9_r;
    p_yq       = 24'(s9_r.yr_full) * 24'd1311;
    s10_nxt.yq = p_yq[21:17];
  end

  always_comb begin
    s11_nxt    = s10_r;
    s11_nxt.yr = 7'(s10_r.yr_full - 12'(s10_r.yq) * 12'd100);
  end

  // rejected replies leave every field at zero
  always_comb begin
    out_ok_nxt  = s11_r.ok;
    out_fld_nxt = '0;
    if (s11_r.ok) begin
      out_fld_nxt = {to_bcd(s11_r.yr),
                     5'(to_bcd(7'(s11_r.mon))),
                     6'(to_bcd(7'(s11_r.date))),
                     s11_r.wd + 3'd1,
                     6'(to_bcd(7'(s11_r.hrs))),
                     7'(to_bcd(7'(s11_r.mins))),
                     7'(to_bcd(7'(s11_r.secs)))};
    end
    vld_nxt     = {vld_r[NSTG-2:0], pop};
    out_vld_nxt = vld_r[NSTG-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r      <= s1_nxt;
      s2_r      <= s2_nxt;
      s3_r      <= s3_nxt;
      s4_r      <= s4_nxt;
      s5_r      <= s5_nxt;
      s6_r      <= s6_nxt;
      s7_r      <= s7_nxt;
      s8_r      <= s8_nxt;
      s9_r      <= s9_nxt;
      s10_r     <= s10_nxt;
      s11_r     <= s11_nxt;
      out_ok_r  <= out_ok_nxt;
      out_fld_r <= out_fld_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {{(OUT_DATA_W - FLD_W){1'b0}}, out_fld_r};

  `NSBD_ASSERT_NOW(a_wday_range, out_vld_r && out_ok_r, out_fld_r[WD_LSB +: 3] != 3'd0, "weekday zero")
  `NSBD_ASSERT_NEXT(a_pop_enters, pop, vld_r[0], "popped item missing from pipeline")
  `NSBD_ASSERT_NEXT(a_stall_holds, !adv, $stable(vld_r), "pipeline moved while stalled")

endmodule

`default_nettype wire

// ===== hdl/ntp_seconds_to_bcd_datetime.sv =====
// results pass a queue slot, the conversion stages and the output register
// throughput: one reply per cycle while unstalled, set by the 11-stage conversion pipeline
// a 4-entry queue lets the input side run on while the result side is stalled
// reset: synchronous on rst_n low, empties queue and pipeline, sets offset to -10800 s
`default_nettype none

module ntp_seconds_to_bcd_datetime import nsbd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // mode_byte[7:0], stratum[15:8], packet_length[31:16], source_port[47:32],
  // source_matches[48], transmit_seconds[80:49], zero fill above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // bcd_seconds[6:0], bcd_minutes[13:7], bcd_hours[19:14], bcd_weekday[22:20],
  // bcd_date[28:23], bcd_month[33:29], bcd_year[41:34], zero fill above
  output logic [OUT_DATA_W-1:0] out_tdata,
  // valid_res
  output logic                  out_tuser,
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  // timezone offset, two's complement seconds
  logic [16:0] tz_r, tz_nxt;
  logic        cfg_wr;

  q_stat_t  q_stat;
  q_entry_t push_data;
  q_entry_t head;
  logic     push;
  logic     pop;

  // zero wait states, register decoded on the word address
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_TZ_OFFSET) ? {15'd0, tz_r} : 32'd0;

  always_comb begin
    tz_nxt = tz_r;
    if (cfg_wr && (cfg_paddr[2] == REG_TZ_OFFSET)) begin
      tz_nxt = cfg_pwdata[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tz_r <= TZ_RESET;
    end else begin
      tz_r <= tz_nxt;
    end
  end

  // front: header check and local seconds, one transfer per cycle while the queue is not full
  nsbd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .tz_offset (tz_r),
    .q_stat    (q_stat),
    .push      (push),
    .entry     (push_data)
  );

  // decoupling queue between the front and the conversion pipeline
  nsbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // back: calendar split and bcd packing, stalls as a whole on out_tready
  nsbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== verif/rtc_result_checker.sv =====
`timescale 1ns / 100ps

module rtc_result_checker import nsbd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // mode_byte, stratum, packet_length, source_port, source_matches, transmit_seconds
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // bcd_seconds, bcd_minutes, bcd_hours, bcd_weekday, bcd_date, bcd_month, bcd_year
  input  logic [OUT_DATA_W-1:0] out_tdata,
  // valid_res
  input  logic                  out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  input  logic [31:0]           cfg_prdata,
  input  logic                  cfg_pready,
  output int                    pending_results,
  output int                    fault_count
);

  localparam logic [31:0] EPOCH_GAP_SECS = 32'd2208988800;
  localparam longint SECS_PER_DAY    = 86400;
  localparam longint FOUR_WEEKS_SECS = 28 * 86400;
  localparam longint UTC_MINUS_3     = -10800;
  localparam longint DAYS_0000_03_01 = 719468;
  localparam longint DAYS_PER_ERA    = 146097;

  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] xmit_secs;
    logic        src_match;
    logic [15:0] src_port;
    logic [15:0] pkt_len;
    logic [7:0]  strat;
    logic [7:0]  mode_byte;
  } ntp_reply_t;

  typedef struct packed {
    logic [5:0] pad;
    logic [7:0] year;
    logic [4:0] month;
    logic [5:0] date;
    logic [2:0] weekday;
    logic [5:0] hours;
    logic [6:0] minutes;
    logic [6:0] seconds;
  } rtc_word_t;

  typedef struct packed {
    logic      valid;
    rtc_word_t word;
  } rtc_expect_t;

  rtc_expect_t expected_rtc_q[$];
  longint      tz_secs;
  int          faults;

  function automatic logic [7:0] bcd_pair(input longint v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // civil date split after a four-week bias that keeps the local seconds non-negative
  function automatic rtc_expect_t predict_rtc(input ntp_reply_t r, input longint tz);
    rtc_expect_t e;
    logic [31:0] unix_s;
    longint      t, days, sod, z, era, doe, yoe, yr, doy, mp, mon;
    e = '0;
    if (r.src_match && r.src_port == NTP_SERVER_PORT && r.pkt_len == NTP_PKT_LEN &&
        r.mode_byte[2:0] == NTP_MODE_SERVER && r.strat != 8'd0) begin
      unix_s = r.xmit_secs - EPOCH_GAP_SECS;
      t = longint'({32'd0, unix_s}) + tz + FOUR_WEEKS_SECS;
      days = t / SECS_PER_DAY;
      sod = t % SECS_PER_DAY;
      // back out the bias, count from 0000-03-01
      z = days - 28 + DAYS_0000_03_01;
      era = z / DAYS_PER_ERA;
      doe = z - era * DAYS_PER_ERA;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      yr = yoe + era * 400;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp = (5 * doy + 2) / 153;
      mon = (mp < 10) ? mp + 3 : mp - 9;
      if (mon <= 2) yr++;
      e.valid = 1'b1;
      e.word.seconds = 7'(bcd_pair(sod % 60));
      e.word.minutes = 7'(bcd_pair((sod / 60) % 60));
      e.word.hours = 6'(bcd_pair(sod / 3600));
      // bias is whole weeks, 1970-01-01 was a thursday, sunday counts as 1
      e.word.weekday = 3'((days + 4) % 7 + 1);
      e.word.date = 6'(bcd_pair(doy - (153 * mp + 2) / 5 + 1));
      e.word.month = 5'(bcd_pair(mon));
      e.word.year = bcd_pair(yr % 100);
    end
    return e;
  endfunction

  task automatic show_rtc(input string tag, input rtc_expect_t r);
    $display("  %s valid=%b time=%h:%h:%h wday=%h date=%h month=%h year=%h pad=%h",
             tag, r.valid, r.word.hours, r.word.minutes, r.word.seconds, r.word.weekday,
             r.word.date, r.word.month, r.word.year, r.word.pad);
  endtask

  always @(posedge clk) begin
    ntp_reply_t  reply;
    rtc_expect_t want;
    rtc_expect_t got;
    if (!rst_n) begin
      tz_secs = UTC_MINUS_3;
      expected_rtc_q.delete();
      faults = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr[2] == REG_TZ_OFFSET) begin
        if (cfg_pwrite) begin
          tz_secs = longint'($signed(cfg_pwdata[16:0]));
        end else if (cfg_prdata[16:0] !== 17'(tz_secs)) begin
          if (faults < 10)
            $display("tz offset readback: expected %h got %h", 17'(tz_secs), cfg_prdata[16:0]);
          faults++;
        end
      end
      // pop before push so a result never meets its own transfer
      if (out_tvalid && out_tready) begin
        got.valid = out_tuser;
        got.word = out_tdata;
        if (expected_rtc_q.size() == 0) begin
          if (faults < 10) begin
            $display("result transfer with nothing outstanding at %0t", $realtime);
            show_rtc("got", got);
          end
          faults++;
        end else begin
          want = expected_rtc_q.pop_front();
          if (want.valid !== got.valid || want.word.seconds !== got.word.seconds ||
              want.word.minutes !== got.word.minutes || want.word.hours !== got.word.hours ||
              want.word.weekday !== got.word.weekday || want.word.date !== got.word.date ||
              want.word.month !== got.word.month || want.word.year !== got.word.year ||
              want.word.pad !== got.word.pad) begin
            if (faults < 10) begin
              $display("rtc result mismatch at %0t", $realtime);
              show_rtc("exp", want);
              show_rtc("got", got);
            end
            faults++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        reply = in_tdata;
        expected_rtc_q.push_back(predict_rtc(reply, tz_secs));
      end
    end
    pending_results <= expected_rtc_q.size();
    fault_count <= faults;
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top import nsbd_pkg::*; ();

  // ntp seconds at 1970-01-01 00:00:00 utc
  localparam logic [31:0] NTP_EPOCH_1970 = 32'd2208988800;
  // cycles with no transfer of any kind before the run is called hung
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 68;
  // drain time after the last result, longer than the pipeline latency
  localparam int TAIL_CYCLES = 24;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // mode_byte[7:0], stratum[15:8], packet_length[31:16], source_port[47:32],
  // source_matches[48], transmit_seconds[80:49], zero fill above
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  // bcd_seconds[6:0], bcd_minutes[13:7], bcd_hours[19:14], bcd_weekday[22:20],
  // bcd_date[28:23], bcd_month[33:29], bcd_year[41:34], zero fill above
  logic [OUT_DATA_W-1:0] out_tdata;
  // valid_res
  logic                  out_tuser;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [2:0]            cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int pending_results;
  int fault_count;

  // no idling on either side once set, used for the closing phase
  bit calm_tail;
  // offset currently programmed, used to aim stimulus at local midnights
  int current_tz;

  ntp_seconds_to_bcd_datetime uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // watches both channels and the register port, predicts and compares
  rtc_result_checker rtc_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready),
    .pending_results (pending_results),
    .fault_count     (fault_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // header fields into the stream word, fill bits stay zero
  function automatic logic [IN_DATA_W-1:0] pack_reply(input logic [7:0] mode_b,
      input logic [7:0] strat, input logic [15:0] len, input logic [15:0] port,
      input logic match, input logic [31:0] ts);
    logic [IN_DATA_W-1:0] w;
    w = '0;
    w[80:0] = {ts, match, port, len, strat, mode_b};
    return w;
  endfunction

  // a plain well-formed server reply: version 4, mode server, stratum 2
  function automatic logic [IN_DATA_W-1:0] good_reply(input logic [31:0] ts);
    return pack_reply({5'b00100, NTP_MODE_SERVER}, 8'd2, NTP_PKT_LEN, NTP_SERVER_PORT, 1'b1, ts);
  endfunction

  // mostly well-formed replies with random content, the rest broken in one
  // header field or pure noise
  function automatic logic [IN_DATA_W-1:0] random_reply();
    logic [31:0] ts;
    logic [7:0]  mode_b;
    logic [7:0]  strat;
    logic [15:0] len;
    logic [15:0] port;
    logic        match;
    case ($urandom_range(0, 4))
      0, 1: ts = $urandom;
      // around the 1970 epoch in local time, reaches back into 1969
      2: ts = NTP_EPOCH_1970 - 32'(current_tz) + 32'($urandom_range(0, 400000)) - 32'd200000;
      // either end of the 32-bit range, where the epoch subtraction wraps
      3: ts = $urandom_range(0, 1) ? 32'($urandom_range(0, 100000))
                                   : ~32'($urandom_range(0, 100000));
      // just after or just before a local midnight on a random day
      default: ts = NTP_EPOCH_1970 - 32'(current_tz) + 32'($urandom_range(0, 49710)) * 32'd86400
                    + ($urandom_range(0, 1) ? 32'($urandom_range(0, 90))
                                            : 32'd86399 - 32'($urandom_range(0, 90)));
    endcase
    mode_b = {5'($urandom), NTP_MODE_SERVER};
    strat = 8'($urandom_range(1, 255));
    len = NTP_PKT_LEN;
    port = NTP_SERVER_PORT;
    match = 1'b1;
    case ($urandom_range(0, 19))
      0: mode_b[2:0] = NTP_MODE_SERVER ^ 3'($urandom_range(1, 7));
      1: strat = 8'd0;
      2: len = NTP_PKT_LEN ^ 16'($urandom_range(1, 65535));
      3: port = NTP_SERVER_PORT ^ 16'($urandom_range(1, 65535));
      4: match = 1'b0;
      5: begin
        mode_b = 8'($urandom);
        strat = 8'($urandom);
        len = 16'($urandom);
        port = 16'($urandom);
        match = 1'($urandom);
        ts = $urandom;
      end
      default: ;
    endcase
    return pack_reply(mode_b, strat, len, port, match, ts);
  endfunction

  // one register access: setup cycle then access cycle, held until pready
  task automatic apb_access(input logic wr, input logic [31:0] wdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {REG_TZ_OFFSET, 2'b00};
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // present one reply and hold it until the transfer, then maybe a gap
  task automatic send_reply(input logic [IN_DATA_W-1:0] d);
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do begin
      @(posedge clk);
    end while (!in_tready);
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // stop sending until every outstanding result has been taken
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // result side: random stall bursts with stretches of steady ready between
  initial begin : result_backpressure
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat (($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // hang detection: counts cycles in which nothing at all is transferred
  initial begin : stall_watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("ntp_seconds_to_bcd_datetime test failed");
    $finish;
  end

  initial begin : stimulus
    logic [IN_DATA_W-1:0] opening_q[$];
    int                   tz_plan[7];
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    rst_n <= 1'b0;
    calm_tail = 1'b0;
    current_tz = -10800;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed replies under the reset offset of utc-3
    // 1970 epoch itself: local time lands on 1969-12-31 21:00
    opening_q.push_back(good_reply(NTP_EPOCH_1970));
    // local 1970-01-01 00:00:00 and the second before the epoch
    opening_q.push_back(good_reply(NTP_EPOCH_1970 + 32'd10800));
    opening_q.push_back(good_reply(NTP_EPOCH_1970 - 32'd1));
    // zero and all-ones transmit seconds, the subtraction wraps for zero
    opening_q.push_back(good_reply(32'd0));
    opening_q.push_back(good_reply(32'hFFFF_FFFF));
    // local 2000-02-29 00:00:00, leap day of a century leap year
    opening_q.push_back(good_reply(32'd3160782000));
    // local 1999-12-31 23:59:59, year rollover
    opening_q.push_back(good_reply(32'd3155684399));
    // local 2100-03-01 00:00:00, past 2099 and after a non-leap february
    opening_q.push_back(good_reply(32'd2021574704));
    // server mode with every upper bit of the first byte set, top stratum
    opening_q.push_back(pack_reply(8'hFC, 8'hFF, NTP_PKT_LEN, NTP_SERVER_PORT, 1'b1, $urandom));
    // rejected replies, one broken header field each
    opening_q.push_back(pack_reply(8'h23, 8'd2, NTP_PKT_LEN, NTP_SERVER_PORT, 1'b1, $urandom));
    opening_q.push_back(pack_reply(8'hFD, 8'd2, NTP_PKT_LEN, NTP_SERVER_PORT, 1'b1, $urandom));
    opening_q.push_back(pack_reply(8'h00, 8'd2, NTP_PKT_LEN, NTP_SERVER_PORT, 1'b1, $urandom));
    opening_q.push_back(pack_reply(8'h24, 8'd0, NTP_PKT_LEN, NTP_SERVER_PORT, 1'b1, $urandom));
    opening_q.push_back(pack_reply(8'h24, 8'd2, NTP_PKT_LEN - 16'd1, NTP_SERVER_PORT, 1'b1,
                                   $urandom));
    opening_q.push_back(pack_reply(8'h24, 8'd2, NTP_PKT_LEN + 16'd1, NTP_SERVER_PORT, 1'b1,
                                   $urandom));
    opening_q.push_back(pack_reply(8'h24, 8'd2, 16'h8030, NTP_SERVER_PORT, 1'b1, $urandom));
    opening_q.push_back(pack_reply(8'h24, 8'd2, NTP_PKT_LEN, NTP_SERVER_PORT - 16'd1, 1'b1,
                                   $urandom));
    opening_q.push_back(pack_reply(8'h24, 8'd2, NTP_PKT_LEN, 16'h807B, 1'b1, $urandom));
    opening_q.push_back(pack_reply(8'h24, 8'd2, NTP_PKT_LEN, NTP_SERVER_PORT, 1'b0, $urandom));
    // all fields zero, all fields ones
    opening_q.push_back(pack_reply(8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'd0));
    opening_q.push_back(pack_reply(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF));
    foreach (opening_q[i]) send_reply(opening_q[i]);
    wait_all_results();

    // offset sweep: both ends of the normal range, both ends of the 17-bit
    // pattern, zero, then a random legal value and a random raw pattern
    tz_plan[0] = -43200;
    tz_plan[1] = 50400;
    tz_plan[2] = -65536;
    tz_plan[3] = 65535;
    tz_plan[4] = 0;
    tz_plan[5] = int'($urandom_range(0, 93600)) - 43200;
    tz_plan[6] = int'($urandom_range(0, 131071)) - 65536;

    foreach (tz_plan[p]) begin
      calm_tail = (p == $size(tz_plan) - 1);
      current_tz = tz_plan[p];
      // block is idle here, so the new offset cannot touch a reply in flight
      apb_access(1'b1, {15'($urandom), 17'(current_tz)});
      apb_access(1'b0, $urandom);
      // local midnight at the epoch, the epoch, and the second before the epoch
      send_reply(good_reply(NTP_EPOCH_1970 - 32'(current_tz)));
      send_reply(good_reply(NTP_EPOCH_1970));
      send_reply(good_reply(NTP_EPOCH_1970 - 32'd1));
      repeat (PHASE_ITEMS) begin
        send_reply(random_reply());
        // occasional full drain with the sender held off
        if (!calm_tail && $urandom_range(0, 49) == 0) wait_all_results();
      end
      wait_all_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_results == 0)
      $display("ntp_seconds_to_bcd_datetime test passed");
    else
      $display("ntp_seconds_to_bcd_datetime test failed");
    $finish;
  end

endmodule

// ===== ntp_seconds_to_bcd_datetime.f =====
+incdir+hdl
hdl/nsbd_pkg.sv
hdl/nsbd_front.sv
hdl/nsbd_queue.sv
hdl/nsbd_back.sv
hdl/ntp_seconds_to_bcd_datetime.sv
verif/rtc_result_checker.sv
verif/tb_top.sv
